// ===== rtl/lsi_pkg.sv =====
// Shared constants, codes and control structs for the line start index block.
`timescale 1ns / 1ps

package lsi_pkg;

    localparam int MAX_LINES   = 4096;
    localparam int OFFSET_BITS = 20;
    localparam int LINE_BITS   = 13;
    localparam int CU_BITS     = 16;
    localparam int REQ_BITS    = 2;
    localparam int STATUS_BITS = 2;

    localparam logic [CU_BITS-1:0]     ASCII_MAX    = 16'h007F;
    localparam logic [CU_BITS-1:0]     NEWLINE_UNIT = 16'h000A;
    localparam logic [OFFSET_BITS-1:0] LEN_MAX      = {OFFSET_BITS{1'b1}};

    // request codes
    localparam logic [REQ_BITS-1:0] REQ_UNIT  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_LINE  = 2'd2;
    localparam logic [REQ_BITS-1:0] REQ_COL   = 2'd3;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_BAD = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVF = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic take;     // beat accepted this cycle
        logic step;     // one binary search step
        logic q2_fin;   // deliver line-for-offset result
        logic q3_hi;    // capture line start and flag, read next start
        logic q3_end;   // capture line end
        logic q3_fin;   // deliver offset-for-line result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [REQ_BITS-1:0] req;
        logic                q3_bad;
        logic                srch_done;
    } t_sts;

endpackage

// ===== rtl/lsi_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lsi_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lsi_ctrl.sv =====
// Request sequencer: accepts beats and steps the datapath through each query.
`timescale 1ns / 1ps

module lsi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output lsi_pkg::t_cmd o_cmd,
    input  lsi_pkg::t_sts i_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_Q2FIN = 3'd2;
    localparam logic [2:0] S_Q3A   = 3'd3;
    localparam logic [2:0] S_Q3B   = 3'd4;
    localparam logic [2:0] S_Q3C   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.take = i_start;
                if (i_start) begin
                    priority if (i_sts.req == lsi_pkg::REQ_LINE) begin
                        n_state = S_SRCH;
                    end else if (i_sts.req == lsi_pkg::REQ_COL && !i_sts.q3_bad) begin
                        n_state = S_Q3A;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SRCH: begin
                o_cmd.step = 1'b1;
                if (i_sts.srch_done) begin
                    n_state = S_Q2FIN;
                end
            end
            S_Q2FIN: begin
                o_cmd.q2_fin = 1'b1;
                n_state      = S_IDLE;
            end
            S_Q3A: begin
                o_cmd.q3_hi = 1'b1;
                n_state     = S_Q3B;
            end
            S_Q3B: begin
                o_cmd.q3_end = 1'b1;
                n_state      = S_Q3C;
            end
            S_Q3C: begin
                o_cmd.q3_fin = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/lsi_dp.sv =====
// Datapath: text length, line count, line start and flag memories, search and result registers.
`timescale 1ns / 1ps

module lsi_dp #(
    parameter int MAX_LINES = lsi_pkg::MAX_LINES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsi_pkg::t_cmd                       i_cmd,
    output lsi_pkg::t_sts                       o_sts,
    input  logic [lsi_pkg::REQ_BITS-1:0]        i_req_type,
    input  logic [lsi_pkg::CU_BITS-1:0]         i_code_unit,
    input  logic [lsi_pkg::OFFSET_BITS-1:0]     i_query_offset,
    input  logic [lsi_pkg::LINE_BITS-1:0]       i_query_line,
    input  logic [lsi_pkg::OFFSET_BITS-1:0]     i_query_column,
    output logic                                o_strobe,
    output logic [lsi_pkg::STATUS_BITS-1:0]     o_status,
    output logic [lsi_pkg::OFFSET_BITS-1:0]     o_answer,
    output logic                                o_line_is_ascii,
    output logic [lsi_pkg::LINE_BITS-1:0]       o_lines_now
);

    localparam int IW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int OB = lsi_pkg::OFFSET_BITS;
    localparam int LB = lsi_pkg::LINE_BITS;
    localparam int SB = lsi_pkg::STATUS_BITS;

    // control state
    logic [OB-1:0] r_len,    n_len;
    logic [CW-1:0] r_total,  n_total;
    logic          r_run,    n_run;
    logic          r_strobe, n_strobe;

    // payload state
    logic [CW-1:0] r_lo,     n_lo;
    logic [CW-1:0] r_hi,     n_hi;
    logic [IW-1:0] r_mid,    n_mid;
    logic [OB-1:0] r_off,    n_off;
    logic [IW-1:0] r_lidx,   n_lidx;
    logic          r_last,   n_last;
    logic [OB-1:0] r_colm1,  n_colm1;
    logic [OB-1:0] r_start,  n_start;
    logic [OB-1:0] r_end,    n_end;
    logic          r_flag,   n_flag;
    logic [SB-1:0] r_status, n_status;
    logic [OB-1:0] r_answer, n_answer;
    logic          r_ascii,  n_ascii;

    // memory ports
    logic [IW-1:0] tab_raddr, flag_raddr;
    logic [OB-1:0] tab_rdata;
    logic          flag_rdata;
    logic          add_line;

    logic          is_nl;
    logic          unit_ok;
    logic          q3_bad;
    logic [OB-1:0] probe;
    logic          probe_le;
    logic [OB-1:0] span;

    assign is_nl   = (i_code_unit == lsi_pkg::NEWLINE_UNIT);
    assign unit_ok = (r_len != lsi_pkg::LEN_MAX) && !(is_nl && (r_total == CW'(MAX_LINES)));
    assign add_line = i_cmd.take && (i_req_type == lsi_pkg::REQ_UNIT) && unit_ok && is_nl;

    assign q3_bad = (i_query_line == '0) || (i_query_column == '0)
                 || (32'(i_query_line) > 32'(r_total));

    // entry 0 of the start table is never written; its value is taken as zero
    assign probe    = (r_mid == '0) ? '0 : tab_rdata;
    assign probe_le = (probe <= r_off);
    assign span     = r_end - r_start;

    always_comb begin
        n_len      = r_len;
        n_total    = r_total;
        n_run      = r_run;
        n_strobe   = 1'b0;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_off      = r_off;
        n_lidx     = r_lidx;
        n_last     = r_last;
        n_colm1    = r_colm1;
        n_start    = r_start;
        n_end      = r_end;
        n_flag     = r_flag;
        n_status   = r_status;
        n_answer   = r_answer;
        n_ascii    = r_ascii;
        tab_raddr  = r_mid;
        flag_raddr = r_lidx;

        if (i_cmd.take) begin
            unique case (i_req_type)
                lsi_pkg::REQ_UNIT: begin
                    n_strobe = 1'b1;
                    n_answer = '0;
                    n_ascii  = 1'b0;
                    if (!unit_ok) begin
                        n_status = lsi_pkg::ST_OVF;
                    end else begin
                        n_status = lsi_pkg::ST_OK;
                        n_len    = r_len + 1'b1;
                        if (i_code_unit > lsi_pkg::ASCII_MAX) begin
                            n_run = 1'b0;
                        end
                        if (is_nl) begin
                            n_total = r_total + 1'b1;
                            n_run   = 1'b1;
                        end
                    end
                end
                lsi_pkg::REQ_CLEAR: begin
                    n_strobe = 1'b1;
                    n_status = lsi_pkg::ST_OK;
                    n_answer = '0;
                    n_ascii  = 1'b0;
                    n_len    = '0;
                    n_total  = CW'(1);
                    n_run    = 1'b1;
                end
                lsi_pkg::REQ_LINE: begin
                    n_off     = (i_query_offset > r_len) ? r_len : i_query_offset;
                    n_lo      = '0;
                    n_hi      = r_total;
                    n_mid     = IW'(r_total >> 1);
                    tab_raddr = n_mid;
                end
                lsi_pkg::REQ_COL: begin
                    if (q3_bad) begin
                        n_strobe = 1'b1;
                        n_status = lsi_pkg::ST_BAD;
                        n_answer = '0;
                        n_ascii  = 1'b0;
                    end else begin
                        n_lidx     = IW'(i_query_line - 1'b1);
                        n_last     = (32'(i_query_line) == 32'(r_total));
                        n_colm1    = i_query_column - 1'b1;
                        tab_raddr  = n_lidx;
                        flag_raddr = n_lidx;
                    end
                end
            endcase
        end

        if (i_cmd.step) begin
            if (probe_le) begin
                n_lo = CW'(r_mid) + CW'(1);
            end else begin
                n_hi = CW'(r_mid);
            end
            n_mid      = IW'(n_lo + ((n_hi - n_lo) >> 1));
            tab_raddr  = n_mid;
            // fetch the flag of the found line, used once the search closes
            flag_raddr = IW'(n_lo - 1'b1);
        end

        if (i_cmd.q2_fin) begin
            n_strobe = 1'b1;
            n_status = lsi_pkg::ST_OK;
            n_answer = OB'(r_lo);
            n_ascii  = (r_lo >= r_total) ? r_run : flag_rdata;
        end

        if (i_cmd.q3_hi) begin
            n_start   = (r_lidx == '0) ? '0 : tab_rdata;
            n_flag    = r_last ? r_run : flag_rdata;
            tab_raddr = r_lidx + 1'b1;
        end

        if (i_cmd.q3_end) begin
            if (r_last) begin
                n_end = r_len;
            end else begin
                n_end = (tab_rdata == '0) ? '0 : tab_rdata - 1'b1;
            end
        end

        if (i_cmd.q3_fin) begin
            n_strobe = 1'b1;
            if (r_end < r_start) begin
                n_status = lsi_pkg::ST_BAD;
                n_answer = '0;
                n_ascii  = 1'b0;
            end else begin
                n_status = lsi_pkg::ST_OK;
                n_answer = (r_colm1 > span) ? r_end : r_start + r_colm1;
                n_ascii  = r_flag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_total  <= CW'(1);
            r_run    <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_len    <= n_len;
            r_total  <= n_total;
            r_run    <= n_run;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_off    <= n_off;
        r_lidx   <= n_lidx;
        r_last   <= n_last;
        r_colm1  <= n_colm1;
        r_start  <= n_start;
        r_end    <= n_end;
        r_flag   <= n_flag;
        r_status <= n_status;
        r_answer <= n_answer;
        r_ascii  <= n_ascii;
    end

    lsi_ram #(
        .WIDTH (OB),
        .DEPTH (MAX_LINES)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (add_line),
        .i_waddr (IW'(r_total)),
        .i_wdata (r_len + 1'b1),
        .i_raddr (tab_raddr),
        .o_rdata (tab_rdata)
    );

    lsi_ram #(
        .WIDTH (1),
        .DEPTH (MAX_LINES)
    ) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (add_line),
        .i_waddr (IW'(r_total - 1'b1)),
        .i_wdata (r_run),
        .i_raddr (flag_raddr),
        .o_rdata (flag_rdata)
    );

    assign o_sts.req       = i_req_type;
    assign o_sts.q3_bad    = q3_bad;
    assign o_sts.srch_done = (n_lo == n_hi);

    assign o_strobe        = r_strobe;
    assign o_status        = r_status;
    assign o_answer        = r_answer;
    assign o_line_is_ascii = r_ascii;
    assign o_lines_now     = LB'(r_total);

endmodule

// ===== rtl/line_start_index.sv =====
// Top level of the line start index: sequencer plus datapath, with interface checks.
`timescale 1ns / 1ps

// Builds a table of line start offsets from a stream of UTF-16 code units and
// answers line-for-offset and offset-for-line-column queries. A beat is taken
// when start is high and busy is low; every beat gives exactly one result,
// shown on the o_ ports for one cycle with o_strobe high, and the receiver
// cannot stall it. Code units and clear requests leave busy low, so they
// stream one per cycle; the result follows in the cycle after acceptance. A
// line-for-offset query binary-searches the start table through its single
// read port, one table read per cycle, with busy high through the search
// and its closing step; the result appears as busy falls. An offset-for-line
// query reads the line's start and the next line's start one after the
// other and holds busy through its three steps; invalid line or column
// arguments are answered at once. The memories need no clearing pass after
// reset: the block is ready at once.
module line_start_index #(
    parameter int MAX_LINES = lsi_pkg::MAX_LINES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lsi_pkg::REQ_BITS-1:0]        i_req_type,
    input  logic [lsi_pkg::CU_BITS-1:0]         i_code_unit,
    input  logic [lsi_pkg::OFFSET_BITS-1:0]     i_query_offset,
    input  logic [lsi_pkg::LINE_BITS-1:0]       i_query_line,
    input  logic [lsi_pkg::OFFSET_BITS-1:0]     i_query_column,
    output logic                                o_strobe,
    output logic [lsi_pkg::STATUS_BITS-1:0]     o_status,
    output logic [lsi_pkg::OFFSET_BITS-1:0]     o_answer,
    output logic                                o_line_is_ascii,
    output logic [lsi_pkg::LINE_BITS-1:0]       o_lines_now
);

    lsi_pkg::t_cmd cmd;
    lsi_pkg::t_sts sts;

    lsi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    lsi_dp #(
        .MAX_LINES (MAX_LINES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_req_type      (i_req_type),
        .i_code_unit     (i_code_unit),
        .i_query_offset  (i_query_offset),
        .i_query_line    (i_query_line),
        .i_query_column  (i_query_column),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_answer        (o_answer),
        .o_line_is_ascii (o_line_is_ascii),
        .o_lines_now     (o_lines_now)
    );

    // code units and clears answer in the very next cycle
    a_unit_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == lsi_pkg::REQ_UNIT
                            || i_req_type == lsi_pkg::REQ_CLEAR)) |=> o_strobe)
        else $error("no result one cycle after a code unit or clear beat");

    // overflow can only come from a code unit beat
    a_ovf_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == lsi_pkg::ST_OVF) |-> $past(i_req_type) == lsi_pkg::REQ_UNIT)
        else $error("overflow status for a beat that is not a code unit");

    // a query ends with its result
    a_fell_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("query finished without a result");

    // no result appears while a query is in flight
    a_quiet_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !o_strobe)
        else $error("result strobe while busy");

endmodule

// ===== verif/line_start_index_check.sv =====
// Checker for the line start index: predicts every reply from the accepted beats and compares.
`timescale 1ns / 1ps

module line_start_index_check
    import lsi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    input  logic                   busy,
    input  logic [REQ_BITS-1:0]    i_req_type,
    input  logic [CU_BITS-1:0]     i_code_unit,
    input  logic [OFFSET_BITS-1:0] i_query_offset,
    input  logic [LINE_BITS-1:0]   i_query_line,
    input  logic [OFFSET_BITS-1:0] i_query_column,
    input  logic                   i_strobe,
    input  logic [STATUS_BITS-1:0] i_status,
    input  logic [OFFSET_BITS-1:0] i_answer,
    input  logic                   i_line_is_ascii,
    input  logic [LINE_BITS-1:0]   i_lines_now,
    output int                     o_fail_count,
    output int                     o_replies_owed
);

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [OFFSET_BITS-1:0] answer;
        logic                   ascii;
        logic [LINE_BITS-1:0]   lines;
    } t_reply;

    // mirror of the line table
    bit   [OFFSET_BITS-1:0] starts [MAX_LINES];
    bit                     closed_ascii [MAX_LINES];
    logic [OFFSET_BITS-1:0] text_len;
    int                     line_cnt;
    logic                   run_ascii;

    t_reply replies_due [$];
    int     fails = 0;
    int     owed = 0;

    assign o_fail_count   = fails;
    assign o_replies_owed = owed;

    function automatic void clear_text();
        text_len  = '0;
        line_cnt  = 1;
        run_ascii = 1'b1;
        starts[0] = '0;
    endfunction

    // the last line is still open, so its flag is the running one
    function automatic logic ascii_of(input int idx);
        return (idx + 1 >= line_cnt) ? run_ascii : closed_ascii[idx];
    endfunction

    function automatic t_reply apply_request(input logic [REQ_BITS-1:0] req,
                                             input logic [CU_BITS-1:0] cu,
                                             input logic [OFFSET_BITS-1:0] ofs,
                                             input logic [LINE_BITS-1:0] ln,
                                             input logic [OFFSET_BITS-1:0] col);
        t_reply          r;
        int              lo;
        int              hi;
        int              mid;
        longint unsigned spot;
        longint unsigned line_begin;
        longint unsigned line_end;
        r = '0;
        case (req)
            REQ_UNIT: begin
                if (text_len == LEN_MAX || (cu == NEWLINE_UNIT && line_cnt >= MAX_LINES)) begin
                    r.status = ST_OVF;
                end else begin
                    if (cu > ASCII_MAX) run_ascii = 1'b0;
                    text_len = text_len + 1'b1;
                    if (cu == NEWLINE_UNIT) begin
                        closed_ascii[line_cnt-1] = run_ascii;
                        starts[line_cnt] = text_len;
                        line_cnt++;
                        run_ascii = 1'b1;
                    end
                end
            end
            REQ_CLEAR: clear_text();
            REQ_LINE: begin
                spot = (ofs > text_len) ? text_len : ofs;
                lo = 0;
                hi = line_cnt;
                // find the first start beyond the offset
                while (lo < hi) begin
                    mid = lo + (hi - lo) / 2;
                    if (starts[mid] <= spot) lo = mid + 1;
                    else hi = mid;
                end
                r.answer = OFFSET_BITS'(lo);
                r.ascii  = (lo > 0) ? ascii_of(lo - 1) : 1'b0;
            end
            REQ_COL: begin
                if (ln == 0 || col == 0 || ln > line_cnt) begin
                    r.status = ST_BAD;
                end else begin
                    line_begin = starts[ln-1];
                    if (ln < line_cnt) begin
                        line_end = (starts[ln] > 0) ? starts[ln] - 1 : 0;
                    end else begin
                        line_end = text_len;
                    end
                    if (line_end < line_begin) begin
                        r.status = ST_BAD;
                    end else begin
                        spot = line_begin + col - 1;
                        if (spot > line_end) spot = line_end;
                        r.answer = OFFSET_BITS'(spot);
                        r.ascii  = ascii_of(ln - 1);
                    end
                end
            end
        endcase
        r.lines = LINE_BITS'(line_cnt);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_reply due;
        if (!i_rst_n) begin
            clear_text();
            replies_due.delete();
        end else begin
            if (start && !busy) begin
                due = apply_request(i_req_type, i_code_unit, i_query_offset,
                                    i_query_line, i_query_column);
                replies_due = {replies_due, due};
            end
            if (i_strobe) begin
                if (replies_due.size() == 0) begin
                    $error("result beat with no request outstanding");
                    fails++;
                end else begin
                    due = replies_due.pop_front();
                    if (i_status !== due.status) begin
                        $error("status: expected %0d, got %0d", due.status, i_status);
                        fails++;
                    end
                    if (i_answer !== due.answer) begin
                        $error("answer: expected %0d, got %0d", due.answer, i_answer);
                        fails++;
                    end
                    if (i_line_is_ascii !== due.ascii) begin
                        $error("line_is_ascii: expected %0d, got %0d", due.ascii,
                               i_line_is_ascii);
                        fails++;
                    end
                    if (i_lines_now !== due.lines) begin
                        $error("lines_now: expected %0d, got %0d", due.lines, i_lines_now);
                        fails++;
                    end
                end
            end
        end
        owed = replies_due.size();
    end

endmodule

// ===== verif/line_start_index_test.sv =====
// Testbench top for the line start index: reset, stimulus, run limit and verdict.
`timescale 1ns / 1ps

module line_start_index_test;
    import lsi_pkg::*;

    localparam int CYCLE_LIMIT  = 400_000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 30;

    typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} t_pace;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic [REQ_BITS-1:0]    i_req_type = '0;
    logic [CU_BITS-1:0]     i_code_unit = '0;
    logic [OFFSET_BITS-1:0] i_query_offset = '0;
    logic [LINE_BITS-1:0]   i_query_line = '0;
    logic [OFFSET_BITS-1:0] i_query_column = '0;
    logic                   busy;
    logic                   o_strobe;
    logic [STATUS_BITS-1:0] o_status;
    logic [OFFSET_BITS-1:0] o_answer;
    logic                   o_line_is_ascii;
    logic [LINE_BITS-1:0]   o_lines_now;

    int    fail_count;
    int    replies_owed;
    int    cycle_count = 0;
    t_pace pace = PACE_RANDOM;
    // rough view of the text, only to shape the stimulus
    int    len_seen = 0;
    int    lines_seen = 1;

    always #5 i_clk = ~i_clk;

    line_start_index dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_code_unit    (i_code_unit),
        .i_query_offset (i_query_offset),
        .i_query_line   (i_query_line),
        .i_query_column (i_query_column),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_answer       (o_answer),
        .o_line_is_ascii(o_line_is_ascii),
        .o_lines_now    (o_lines_now)
    );

    line_start_index_check u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_code_unit    (i_code_unit),
        .i_query_offset (i_query_offset),
        .i_query_line   (i_query_line),
        .i_query_column (i_query_column),
        .i_strobe       (o_strobe),
        .i_status       (o_status),
        .i_answer       (o_answer),
        .i_line_is_ascii(o_line_is_ascii),
        .i_lines_now    (o_lines_now),
        .o_fail_count   (fail_count),
        .o_replies_owed (replies_owed)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[line_start_index] ERROR");
            $finish;
        end
    end

    // call at a rising edge; returns at the edge that accepts the beat
    task automatic issue(input logic [REQ_BITS-1:0] req, input logic [CU_BITS-1:0] cu,
                         input logic [OFFSET_BITS-1:0] ofs, input logic [LINE_BITS-1:0] ln,
                         input logic [OFFSET_BITS-1:0] col);
        int gap;
        case (pace)
            PACE_FULL:   gap = 0;
            PACE_RANDOM: gap = $urandom_range(0, 18);
            default:     gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
        endcase
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_req_type     <= req;
        i_code_unit    <= cu;
        i_query_offset <= ofs;
        i_query_line   <= ln;
        i_query_column <= col;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_unit(input logic [CU_BITS-1:0] cu);
        if (len_seen < LEN_MAX && !(cu == NEWLINE_UNIT && lines_seen >= MAX_LINES)) begin
            len_seen++;
            if (cu == NEWLINE_UNIT) lines_seen++;
        end
        issue(REQ_UNIT, cu, $urandom, $urandom, $urandom);
    endtask

    task automatic send_clear();
        len_seen   = 0;
        lines_seen = 1;
        issue(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial begin
        logic [CU_BITS-1:0] opening_units [9];
        logic [CU_BITS-1:0] cu;
        int                 n;
        int                 pick;
        int                 sel;
        opening_units = '{16'h0041, 16'h0000, 16'hFFFF, ASCII_MAX, 16'h0080, NEWLINE_UNIT,
                          16'h0041, NEWLINE_UNIT, NEWLINE_UNIT};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty text: clamping and argument checks
        issue(REQ_LINE, 0, 0, 0, 0);
        issue(REQ_LINE, 0, LEN_MAX, 0, 0);
        issue(REQ_COL, 0, 0, 1, 1);
        issue(REQ_COL, 0, 0, 0, 5);
        issue(REQ_COL, 0, 0, 1, 0);
        issue(REQ_COL, 0, 0, 2, 1);
        issue(REQ_COL, 0, 0, 13'h1FFF, 20'hFFFFF);
        // a non-ASCII line, an ASCII line, an empty line and an empty open line
        foreach (opening_units[i]) send_unit(opening_units[i]);
        issue(REQ_LINE, 0, 5, 0, 0);
        issue(REQ_LINE, 0, 6, 0, 0);
        issue(REQ_LINE, 0, 9, 0, 0);
        issue(REQ_LINE, 0, 100, 0, 0);
        issue(REQ_COL, 0, 0, 1, 3);
        issue(REQ_COL, 0, 0, 1, 20'hFFFFF);
        issue(REQ_COL, 0, 0, 3, 2);
        issue(REQ_COL, 0, 0, 4, 7);
        issue(REQ_COL, 0, 0, 5, 1);
        send_clear();
        issue(REQ_LINE, 0, 5, 0, 0);

        // random text with queries mostly aimed inside it
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) pace = t_pace'($urandom_range(0, 2));
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 9);
            if (pick < 52) begin
                if (sel < 6) cu = $urandom_range(16'h0020, 16'h007E);
                else if (sel < 8) cu = NEWLINE_UNIT;
                else if (sel < 9) cu = $urandom_range(ASCII_MAX + 1, 16'hFFFF);
                else cu = $urandom;
                send_unit(cu);
            end else if (pick < 72) begin
                if (sel < 7) issue(REQ_LINE, $urandom, $urandom_range(0, len_seen),
                                   $urandom, $urandom);
                else if (sel < 8) issue(REQ_LINE, $urandom, len_seen, $urandom, $urandom);
                else issue(REQ_LINE, $urandom, $urandom, $urandom, $urandom);
            end else if (pick < 99) begin
                if (sel < 5) issue(REQ_COL, $urandom, $urandom, $urandom_range(1, lines_seen),
                                   $urandom_range(1, 12));
                else if (sel < 7) issue(REQ_COL, $urandom, $urandom,
                                        $urandom_range(1, lines_seen), $urandom);
                else if (sel < 8) issue(REQ_COL, $urandom, $urandom,
                                        $urandom_range(1, lines_seen), 1);
                else if ($urandom_range(0, 3) == 0) issue(REQ_COL, $urandom, $urandom, 0,
                                                          $urandom);
                else if ($urandom_range(0, 2) == 0) issue(REQ_COL, $urandom, $urandom,
                                                          $urandom_range(1, lines_seen), 0);
                else if ($urandom_range(0, 1) == 0) issue(REQ_COL, $urandom, $urandom,
                                                          lines_seen + 1, 1);
                else issue(REQ_COL, $urandom, $urandom, $urandom, $urandom);
            end else begin
                send_clear();
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        wait (replies_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[line_start_index] OK");
        end else begin
            $display("[line_start_index] ERROR");
        end
        $finish;
    end

endmodule
